[rtl/core/keyed_entry_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Keyed entry table assertion macros
// Shared concurrent assertion wrappers for the table's checker.
// ----------------------------------------------------------------------------
`ifndef KEYED_ENTRY_TABLE_TOP_DEFINES_SVH
`define KEYED_ENTRY_TABLE_TOP_DEFINES_SVH

// Clocked assertion with a synchronous active-low reset as disable
`define KET_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion on the block clock and reset
`define KET_ASSERT(label, prop, msg) \
    `KET_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

[rtl/core/ket_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed entry table package
// Request and response types, operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

    localparam int KEY_W     = 16;
    localparam int CNT_W     = 7;
    localparam int STATUS_W  = 3;
    localparam int PAYLOAD_W = 64;

    // operation codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_GET    = 2'd2;
    localparam logic [1:0] FN_UPDATE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_TAKEN   = 3'd4;

    // register map (word index taken from paddr[2])
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]           func;
        logic [KEY_W-1:0]     key;
        logic [KEY_W-1:0]     new_key;
        logic [PAYLOAD_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] found_payload;
        logic [CNT_W-1:0]     entries_held;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/core/keyed_entry_table_top.sv]
// ----------------------------------------------------------------------------
// Keyed entry table
// Packed key/payload table with add, delete, get and update by linear scan.
// ----------------------------------------------------------------------------
//  channel    direction  handshake               payload
//  request    in         i_in_valid/o_in_ready   i_in_req  (t_req)
//  response   out        o_out_valid/i_out_ready o_out_rsp (t_rsp)
//  config     in         APB psel/penable        paddr/pwdata/prdata
//
//  One request is handled at a time: the single RAM read port walks every
//  held entry once.
//  Delete shifts later entries down during that same walk.
//  Reset is synchronous: count clears, capacity returns to 64; no clear pass.
//  A finished response waits in the output register; the next request is
//  taken meanwhile, and only the final step waits for the output to free.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_entry_table_top
    import ket_pkg::*;
#(
    parameter int DEPTH         = 64,
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_req        i_in_req,
    // response channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_rsp             o_out_rsp,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = 8 * PAYLOAD_BYTES;
    localparam int RW = KEY_W + PW;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]       r_state, n_state;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_cnt, n_rd_cnt;
    logic             r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_hit, n_hit;
    logic             r_nk_hit, n_nk_hit;
    logic [CNT_W-1:0] r_at, n_at;
    logic [PW-1:0]    r_got, n_got;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out_rsp, n_out_rsp;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [RW-1:0]    ram_rdata;
    logic [KEY_W-1:0] rd_key;
    logic [PW-1:0]    rd_pay;
    logic             out_free;
    logic             table_full;
    logic             cfg_wr;

    // entry storage: key in the upper bits, payload below
    ket_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[RW-1:PW];
    assign rd_pay   = ram_rdata[PW-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    // limit is the smaller of capacity and DEPTH
    assign table_full = (r_count >= r_cap) || (32'(r_count) >= 32'(DEPTH));

    // sequencer: scan all held entries, then commit and respond
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_rd_cnt    = r_rd_cnt;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_hit       = r_hit;
        n_nk_hit    = r_nk_hit;
        n_at        = r_at;
        n_got       = r_got;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_rsp   = r_out_rsp;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_count);
        ram_wdata   = {r_req.key, r_req.payload[PW-1:0]};
        ram_raddr   = AW'(r_rd_cnt);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_req;
                    n_rd_cnt = '0;
                    n_hit    = 1'b0;
                    n_nk_hit = 1'b0;
                    n_got    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one read a cycle
                if (r_rd_cnt < r_count) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_cnt;
                    n_rd_cnt  = r_rd_cnt + 1'b1;
                end else if (!r_chk_vld) begin
                    n_state = S_FINISH;
                end
                // check the entry read last cycle
                if (r_chk_vld) begin
                    if (r_hit && r_req.func == FN_DELETE) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_chk_idx - 1'b1);
                        ram_wdata = ram_rdata;
                    end
                    if (!r_hit && rd_key == r_req.key) begin
                        n_hit = 1'b1;
                        n_at  = r_chk_idx;
                        n_got = rd_pay;
                    end
                    if (rd_key == r_req.new_key) begin
                        n_nk_hit = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_rsp.status           = STAT_OK;
                    n_out_rsp.found_payload    = '0;
                    n_state                    = S_IDLE;
                    case (r_req.func)
                        FN_ADD: begin
                            if (r_hit) begin
                                n_out_rsp.status = STAT_DUP;
                            end else if (table_full) begin
                                n_out_rsp.status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        FN_DELETE: begin
                            if (!r_hit) begin
                                n_out_rsp.status = STAT_MISSING;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        FN_GET: begin
                            if (!r_hit) begin
                                n_out_rsp.status = STAT_MISSING;
                            end else begin
                                n_out_rsp.found_payload = PAYLOAD_W'(r_got);
                            end
                        end
                        default: begin
                            if (!r_hit) begin
                                n_out_rsp.status = STAT_MISSING;
                            end else if (r_nk_hit) begin
                                n_out_rsp.status = STAT_TAKEN;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_at);
                                ram_wdata = {r_req.new_key, r_req.payload[PW-1:0]};
                            end
                        end
                    endcase
                    n_out_rsp.entries_held = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // working and response data
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rd_cnt  <= n_rd_cnt;
        r_chk_idx <= n_chk_idx;
        r_hit     <= n_hit;
        r_nk_hit  <= n_nk_hit;
        r_at      <= n_at;
        r_got     <= n_got;
        r_out_rsp <= n_out_rsp;
    end

    // capacity register write
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata      = (paddr[2] == REG_CAPACITY) ? 32'(r_cap) : '0;
    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

[rtl/core/ket_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/ket_chk.sv]
// ----------------------------------------------------------------------------
// Keyed entry table port checker
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_entry_table_top_defines.svh"

module ket_chk
    import ket_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp o_out_rsp
);

    // a stalled response holds
    `KET_ASSERT(a_rsp_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp), "response changed while stalled")

    // an accepted request closes the request side while it is worked on
    `KET_ASSERT(a_busy_after_req, i_in_valid && o_in_ready |=> !o_in_ready, "ready stayed high after a request")

    // status is one of the defined codes
    `KET_ASSERT(a_status_code, o_out_valid |-> o_out_rsp.status <= STAT_TAKEN, "undefined status code")

    // payload is returned only with an ok status
    `KET_ASSERT(a_payload_zero, o_out_valid && o_out_rsp.status != STAT_OK |-> o_out_rsp.found_payload == '0, "payload on a failed request")

endmodule

bind keyed_entry_table_top ket_chk u_ket_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire

[sim/keyed_entry_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed entry table testbench
// Drives add/delete/get/update requests through the valid/ready request
// channel and checks every response against an in-bench table predictor.
// Capacity is rewritten over the APB port between phases while the block is
// idle. Phases vary the sender gaps and receiver stalls, and one phase holds
// the receiver off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------

module keyed_entry_table_top_tb;
    import ket_pkg::*;

    localparam int DEPTH         = 64;
    localparam int PAYLOAD_BYTES = 8;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
        {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * PAYLOAD_BYTES);
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_LEN      = 400;
    localparam int POOL_SIZE     = 128;

    // clock, reset and block ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_req        i_in_req    = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    wire         o_in_ready;
    wire         o_out_valid;
    t_rsp        o_out_rsp;
    wire  [31:0] prdata;
    wire         pready;

    // request/response bookkeeping
    t_req        req_q[$];
    t_rsp        expect_q[$];
    t_rsp        want_rsp;
    int          err_cnt        = 0;
    int          cyc            = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_go        = 1'b0;
    logic        hold_taken     = 1'b0;
    int          hold_left      = 0;

    // predictor state
    logic [KEY_W-1:0]     key_tbl [DEPTH];
    logic [PAYLOAD_W-1:0] pay_tbl [DEPTH];
    int                   held    = 0;
    logic [CNT_W-1:0]     cap_reg = CAP_RESET;

    logic [KEY_W-1:0]     key_pool [POOL_SIZE];

    keyed_entry_table_top #(
        .DEPTH         (DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // first held entry with key k, or -1
    function automatic int find_entry(logic [KEY_W-1:0] k);
        for (int i = 0; i < held; i++) begin
            if (key_tbl[i] == k) return i;
        end
        return -1;
    endfunction

    // apply one request to the predicted table and return its response
    function automatic t_rsp table_apply(t_req r);
        t_rsp                 res;
        int                   hit;
        int                   lim;
        logic [PAYLOAD_W-1:0] pl;
        res = '0;
        res.status = STAT_OK;
        pl  = r.payload & PAYLOAD_MASK;
        lim = (cap_reg < DEPTH) ? int'(cap_reg) : DEPTH;
        hit = find_entry(r.key);
        case (r.func)
            FN_ADD: begin
                if (hit >= 0) begin
                    res.status = STAT_DUP;
                end else if (held >= lim) begin
                    res.status = STAT_FULL;
                end else begin
                    key_tbl[held] = r.key;
                    pay_tbl[held] = pl;
                    held++;
                end
            end
            FN_DELETE: begin
                if (hit < 0) begin
                    res.status = STAT_MISSING;
                end else begin
                    for (int j = hit; j + 1 < held; j++) begin
                        key_tbl[j] = key_tbl[j + 1];
                        pay_tbl[j] = pay_tbl[j + 1];
                    end
                    held--;
                end
            end
            FN_GET: begin
                if (hit < 0) res.status = STAT_MISSING;
                else res.found_payload = pay_tbl[hit];
            end
            FN_UPDATE: begin
                if (hit < 0) begin
                    res.status = STAT_MISSING;
                end else if (find_entry(r.new_key) >= 0) begin
                    // own key counts as taken too
                    res.status = STAT_TAKEN;
                end else begin
                    key_tbl[hit] = r.new_key;
                    pay_tbl[hit] = pl;
                end
            end
        endcase
        res.entries_held = held[CNT_W-1:0];
        return res;
    endfunction

    task automatic queue_request(input logic [1:0] fn, input logic [KEY_W-1:0] k,
                                 input logic [KEY_W-1:0] nk,
                                 input logic [PAYLOAD_W-1:0] pl);
        t_req r;
        r.func    = fn;
        r.key     = k;
        r.new_key = nk;
        r.payload = pl;
        req_q.push_back(r);
    endtask

    // random requests over the first pool_n pooled keys, adds weighted by add_pct
    task automatic queue_random(input int n, input int pool_n, input int add_pct);
        int               sel;
        logic [1:0]       fn;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] nk;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < add_pct) fn = FN_ADD;
            else if (sel < add_pct + (100 - add_pct) / 3) fn = FN_DELETE;
            else if (sel < add_pct + 2 * (100 - add_pct) / 3) fn = FN_GET;
            else fn = FN_UPDATE;
            k  = ($urandom_range(9) == 0) ? KEY_W'($urandom)
                                          : key_pool[$urandom_range(pool_n - 1)];
            nk = ($urandom_range(1) == 0) ? KEY_W'($urandom)
                                          : key_pool[$urandom_range(pool_n - 1)];
            queue_request(fn, k, nk, {$urandom, $urandom});
        end
    endtask

    // wait until every request is sent and every response has come back;
    // sampled on the falling edge so the rising-edge updates have settled
    task automatic drain;
        while (req_q.size() != 0 || i_in_valid || expect_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of the capacity register: setup cycle then access cycle
    task automatic write_capacity(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {{(32 - CNT_W){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = v;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // request driver: predicts each accepted request, then offers the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expect_q.push_back(table_apply(i_in_req));
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_req   <= req_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and receiver stall control
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expect_q.size() == 0) begin
                    $error("response with nothing expected: status %0d", o_out_rsp.status);
                    err_cnt++;
                end else begin
                    want_rsp = expect_q.pop_front();
                    if (o_out_rsp.status !== want_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               want_rsp.status, o_out_rsp.status);
                        err_cnt++;
                    end
                    if (o_out_rsp.found_payload !== want_rsp.found_payload) begin
                        $error("found_payload: expected %h, got %h",
                               want_rsp.found_payload, o_out_rsp.found_payload);
                        err_cnt++;
                    end
                    if (o_out_rsp.entries_held !== want_rsp.entries_held) begin
                        $error("entries_held: expected %0d, got %0d",
                               want_rsp.entries_held, o_out_rsp.entries_held);
                        err_cnt++;
                    end
                end
            end
            // one long hold-off, counted here
            if (hold_go && !hold_taken) begin
                hold_taken  <= 1'b1;
                hold_left   <= HOLD_LEN;
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, extreme keys and payloads, own-key update
        queue_request(FN_GET,    16'h0000, 16'h0000, '0);
        queue_request(FN_DELETE, 16'hFFFF, 16'h0000, '0);
        queue_request(FN_UPDATE, 16'h0000, 16'hFFFF, '1);
        queue_request(FN_ADD,    16'h0000, 16'hFFFF, '0);
        queue_request(FN_ADD,    16'hFFFF, 16'h0000, '1);
        queue_request(FN_ADD,    16'h0000, 16'h0000, '1);
        queue_request(FN_GET,    16'hFFFF, 16'hFFFF, '0);
        queue_request(FN_UPDATE, 16'h0000, 16'h0000, '1);
        queue_request(FN_UPDATE, 16'h0000, 16'hFFFF, '1);
        queue_request(FN_UPDATE, 16'h0000, 16'h1234, 64'h0123_4567_89AB_CDEF);
        queue_request(FN_GET,    16'h1234, 16'h0000, '0);
        queue_request(FN_ADD,    16'h5555, 16'hAAAA, 64'hA5A5_5A5A_F0F0_0F0F);
        queue_request(FN_DELETE, 16'hFFFF, 16'h0000, '0);
        queue_request(FN_GET,    16'h5555, 16'h0000, '0);
        drain();

        // table full, duplicate reported ahead of full
        write_capacity(7'd2);
        queue_request(FN_ADD, 16'hAAAA, 16'h0000, '1);
        queue_request(FN_ADD, 16'h5555, 16'h0000, '1);
        drain();

        // capacity of zero
        write_capacity(7'd0);
        queue_request(FN_ADD, 16'h0F0F, 16'h0000, '1);
        drain();

        // capacity below the held count: adds refused, the rest still works
        write_capacity(7'd1);
        queue_request(FN_ADD,    16'h3C3C, 16'h0000, '1);
        queue_request(FN_UPDATE, 16'h5555, 16'hA5A5, 64'hFEDC_BA98_7654_3210);
        queue_request(FN_GET,    16'hA5A5, 16'h0000, '0);
        queue_request(FN_DELETE, 16'h1234, 16'h0000, '0);
        queue_request(FN_DELETE, 16'hA5A5, 16'h0000, '0);
        drain();

        // random phases
        write_capacity(7'd64);
        set_idling(0, 0);
        queue_random(120, 16, 40);
        drain();

        write_capacity(7'd1);
        set_idling(63, 0);
        queue_random(100, 8, 35);
        drain();

        // capacity above the table depth, add heavy so the table fills
        write_capacity(7'd127);
        set_idling(0, 63);
        queue_random(150, 96, 70);
        drain();

        // long receiver hold-off while requests keep coming
        write_capacity(7'd64);
        set_idling(13, 13);
        @(posedge i_clk);
        hold_go <= 1'b1;
        queue_random(120, 96, 45);
        drain();

        write_capacity(7'd5);
        set_idling(0, 0);
        queue_random(130, 12, 50);
        drain();

        write_capacity(7'd40);
        set_idling(13, 13);
        queue_random(130, 48, 50);
        drain();

        repeat (20) @(posedge i_clk);
        if (expect_q.size() != 0) begin
            $error("%0d responses never arrived", expect_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
